[rtl/box_average_image_downscaler_top_macros.svh]
// Assertion macros for the box average downscaler
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALER_TOP_MACROS_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BAD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define BAD_ASSERT(label, clk, rst_n, prop, msg)
`define BAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/bad_pkg.sv]
// Package: types, constants and divide table for the box average downscaler
`timescale 1ns / 1ps
`default_nettype none
package bad_pkg;
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_SCALE = 15;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int AREA_W = 8;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;
    localparam logic [1:0] REG_CHANS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic calc;
    } t_cmd;

    typedef struct packed {
        logic emit;
    } t_status;

    typedef logic [255:0][16:0] t_recip_tab;

    // smallest r with r * a >= 65536, found bit by bit
    function automatic t_recip_tab make_recip();
        t_recip_tab t;
        logic [16:0] q;
        t = '0;
        for (int i = 1; i < 256; i++) begin
            q = 17'd0;
            for (int b = 16; b >= 0; b--) begin
                if ((int'(q | (17'd1 << b)) * i) < 65536) q[b] = 1'b1;
            end
            t[i] = q + 17'd1;
        end
        return t;
    endfunction

    localparam t_recip_tab RECIP_TAB = make_recip();

    // reciprocal: ceil(65536/a), exact for 8-bit dividends and a <= 225
    function automatic logic [16:0] recip(input logic [AREA_W-1:0] a);
        return RECIP_TAB[a];
    endfunction
endpackage
`default_nettype wire

[rtl/bad_ctrl.sv]
// Controller state machine: sequences memory read, compute and output
`timescale 1ns / 1ps
`default_nettype none
module bad_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire bad_pkg::t_status i_status,
    output bad_pkg::t_cmd         o_cmd
);
    import bad_pkg::*;
    `include "box_average_image_downscaler_top_macros.svh"
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = i_status.emit ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `BAD_ASSERT_NEXT(a_load_rd, i_clk, i_rst_n, o_cmd.load, o_cmd.rd, "read must follow load")
    `BAD_ASSERT_NEXT(a_rd_calc, i_clk, i_rst_n, o_cmd.rd, o_cmd.calc, "calc must follow read")
    `BAD_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output dropped")
endmodule
`default_nettype wire

[rtl/bad_datapath.sv]
// Datapath: counters, line store, block divide and accumulate
`timescale 1ns / 1ps
`default_nettype none
module bad_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bad_pkg::t_cmd    i_cmd,
    output bad_pkg::t_status      o_status,
    input  wire logic             i_restart,
    input  wire logic [12:0]      i_width,
    input  wire logic [15:0]      i_height,
    input  wire logic [3:0]       i_scale,
    input  wire logic [2:0]       i_chans,
    input  wire logic [7:0]       i_channel_0,
    input  wire logic [7:0]       i_channel_1,
    input  wire logic [7:0]       i_channel_2,
    input  wire logic [7:0]       i_channel_3,
    output logic [7:0]            o_out_channel_0,
    output logic [7:0]            o_out_channel_1,
    output logic [7:0]            o_out_channel_2,
    output logic [7:0]            o_out_channel_3,
    output logic                  o_frame_last
);
    import bad_pkg::*;
    logic [31:0] r_mem [MAX_WIDTH];
    logic [31:0] r_rdata;
    logic [COL_W-1:0] r_col, r_bcol;
    logic [15:0] r_row;
    logic [3:0] r_cib, r_rib;
    logic [7:0] r_px [4];
    logic [AREA_W-1:0] r_area;
    logic r_first, r_lastc, r_lastr, r_flast, r_emit;
    logic [31:0] r_out;

    logic [13:0] w_eff;
    logic [16:0] h_eff;
    logic [3:0] s_eff;
    logic [2:0] c_eff;
    logic [13:0] col_start, col_end;
    logic [16:0] row_start, row_end;
    logic [3:0] bw, bh;
    logic [31:0] sum;

    always_comb begin
        w_eff = (i_width == 13'd0) ? 14'd1 :
                (i_width > 13'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {1'b0, i_width};
        h_eff = (i_height == 16'd0) ? 17'd1 : {1'b0, i_height};
        s_eff = (i_scale == 4'd0) ? 4'd1 : i_scale;
        c_eff = (i_chans == 3'd0) ? 3'd1 : (i_chans > 3'd4) ? 3'd4 : i_chans;
        col_start = 14'(r_col) - 14'(r_cib);
        row_start = 17'(r_row) - 17'(r_rib);
        col_end = col_start + 14'(s_eff);
        row_end = row_start + 17'(s_eff);
        bw = (col_end <= w_eff) ? s_eff : 4'(w_eff - col_start);
        bh = (row_end <= h_eff) ? s_eff : 4'(h_eff - row_start);
        if (bw == 4'd0) bw = 4'd1;
        if (bh == 4'd0) bh = 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= r_mem[r_bcol];
        if (i_cmd.calc) r_mem[r_bcol] <= sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px[0] <= i_channel_0;
            r_px[1] <= i_channel_1;
            r_px[2] <= i_channel_2;
            r_px[3] <= i_channel_3;
            r_area <= 8'(bw) * 8'(bh);
            r_first <= (r_cib == 4'd0) && (r_rib == 4'd0);
            r_lastc <= 5'(r_cib) + 5'd1 >= 5'(bw);
            r_lastr <= 5'(r_rib) + 5'd1 >= 5'(bh);
            r_flast <= (14'(r_col) + 14'd1 >= w_eff) && (17'(r_row) + 17'd1 >= h_eff);
        end
        if (i_cmd.calc) r_out <= sum;
    end

    always_comb begin
        logic [16:0] rc;
        logic [24:0] prod;
        logic [7:0] part;
        rc = recip(r_area);
        sum = r_first ? 32'd0 : r_rdata;
        for (int c = 0; c < 4; c++) begin
            prod = 25'(r_px[c]) * 25'(rc);
            part = sum[8*c +: 8] + prod[23:16];
            sum[8*c +: 8] = (3'(c) < c_eff) ? part : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0; r_row <= '0; r_cib <= '0; r_rib <= '0; r_bcol <= '0;
            r_emit <= 1'b0;
        end else if (i_cmd.calc) begin
            r_emit <= r_lastc && r_lastr;
            if (14'(r_col) + 14'd1 >= w_eff) begin
                r_col <= '0; r_cib <= '0; r_bcol <= '0;
                if (17'(r_row) + 17'd1 >= h_eff) begin
                    r_row <= '0; r_rib <= '0;
                end else begin
                    r_row <= r_row + 16'd1;
                    r_rib <= (r_rib + 4'd1 >= s_eff) ? 4'd0 : r_rib + 4'd1;
                end
            end else begin
                r_col <= r_col + COL_W'(1);
                if (r_cib + 4'd1 >= s_eff) begin
                    r_cib <= '0; r_bcol <= r_bcol + COL_W'(1);
                end else r_cib <= r_cib + 4'd1;
            end
        end
    end

    assign o_status.emit = r_lastc && r_lastr;
    assign o_out_channel_0 = r_out[7:0];
    assign o_out_channel_1 = r_out[15:8];
    assign o_out_channel_2 = r_out[23:16];
    assign o_out_channel_3 = r_out[31:24];
    logic r_flast_q;
    always_ff @(posedge i_clk) if (i_cmd.calc) r_flast_q <= r_flast;
    assign o_frame_last = r_flast_q & r_emit;
endmodule
`default_nettype wire

[rtl/box_average_image_downscaler_top.sv]
// Top level: APB registers, controller and datapath of the box average downscaler
// A new pixel is accepted only after the previous one has gone through the
// read-modify-write of the line store in the controller sequence and any output
// word it gives has been taken while i_stall is low.
// Reset (synchronous, active low) clears the position counters and loads
// the registers with width 640, height 480, scale 2, three channels.
`timescale 1ns / 1ps
`default_nettype none
module box_average_image_downscaler_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_channel_0,
    input  wire logic [7:0]  i_channel_1,
    input  wire logic [7:0]  i_channel_2,
    input  wire logic [7:0]  i_channel_3,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_channel_0,
    output logic [7:0]       o_out_channel_1,
    output logic [7:0]       o_out_channel_2,
    output logic [7:0]       o_out_channel_3,
    output logic             o_frame_last
);
    import bad_pkg::*;
    logic [12:0] r_width;
    logic [15:0] r_height;
    logic [3:0] r_scale;
    logic [2:0] r_chans;
    logic wr, restart;
    t_cmd cmd;
    t_status status;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign restart = wr && (paddr[1:0] == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd640; r_height <= 16'd480; r_scale <= 4'd2; r_chans <= 3'd3;
        end else if (restart) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width <= pwdata[12:0];
                REG_HEIGHT: r_height <= pwdata[15:0];
                REG_SCALE:  r_scale <= pwdata[3:0];
                REG_CHANS:  r_chans <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {19'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_SCALE:  prdata = {28'd0, r_scale};
            REG_CHANS:  prdata = {29'd0, r_chans};
            default:    prdata = '0;
        endcase
    end

    bad_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_status(status), .o_cmd(cmd)
    );

    bad_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_restart(restart), .i_width(r_width), .i_height(r_height),
        .i_scale(r_scale), .i_chans(r_chans),
        .i_channel_0(i_channel_0), .i_channel_1(i_channel_1),
        .i_channel_2(i_channel_2), .i_channel_3(i_channel_3),
        .o_out_channel_0(o_out_channel_0), .o_out_channel_1(o_out_channel_1),
        .o_out_channel_2(o_out_channel_2), .o_out_channel_3(o_out_channel_3),
        .o_frame_last(o_frame_last)
    );
endmodule
`default_nettype wire
